@@ hdl/i2cm_pkg.sv @@
// Package for the single-byte I2C master: command codes, step plan layout,
// result word type and the step decoder. No dependencies.
package i2cm_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam int unsigned STEP_W = 7;
  localparam int unsigned OFF_W  = 5;

  localparam logic [6:0] ADDR_RESET = 7'd24;

  // Segment start steps of the write plan.
  localparam logic [STEP_W-1:0] WR_ADDR_BASE  = 7'd4;
  localparam logic [STEP_W-1:0] WR_RACK0_BASE = 7'd28;
  localparam logic [STEP_W-1:0] WR_DATA_BASE  = 7'd32;
  localparam logic [STEP_W-1:0] WR_RACK1_BASE = 7'd56;
  localparam logic [STEP_W-1:0] WR_STOP_BASE  = 7'd60;
  localparam logic [STEP_W-1:0] WR_LAST       = 7'd62;

  // Segment start steps of the read plan.
  localparam logic [STEP_W-1:0] RD_ADDRW_BASE = 7'd4;
  localparam logic [STEP_W-1:0] RD_RACK0_BASE = 7'd28;
  localparam logic [STEP_W-1:0] RD_RSTRT_BASE = 7'd32;
  localparam logic [STEP_W-1:0] RD_ADDRR_BASE = 7'd36;
  localparam logic [STEP_W-1:0] RD_RACK1_BASE = 7'd60;
  localparam logic [STEP_W-1:0] RD_RECV_BASE  = 7'd64;
  localparam logic [STEP_W-1:0] RD_SACK_BASE  = 7'd89;
  localparam logic [STEP_W-1:0] RD_STOP_BASE  = 7'd92;
  localparam logic [STEP_W-1:0] RD_LAST       = 7'd94;

  typedef enum logic [2:0] {
    SEG_START,
    SEG_ADDR_W,
    SEG_ADDR_R,
    SEG_DATA,
    SEG_RACK,
    SEG_RECV,
    SEG_SACK,
    SEG_STOP
  } seg_t;

  typedef struct packed {
    seg_t              seg;
    logic [OFF_W-1:0]  off;
    logic              last;
  } dec_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       nack_seen;
  } res_t;

  function automatic dec_t step_decode(logic rd, logic [STEP_W-1:0] step);
    dec_t              d;
    logic [STEP_W-1:0] base;
    d.seg = SEG_START;
    base  = '0;
    if (rd) begin
      if (step >= RD_STOP_BASE) begin
        d.seg = SEG_STOP;
        base  = RD_STOP_BASE;
      end else if (step >= RD_SACK_BASE) begin
        d.seg = SEG_SACK;
        base  = RD_SACK_BASE;
      end else if (step >= RD_RECV_BASE) begin
        d.seg = SEG_RECV;
        base  = RD_RECV_BASE;
      end else if (step >= RD_RACK1_BASE) begin
        d.seg = SEG_RACK;
        base  = RD_RACK1_BASE;
      end else if (step >= RD_ADDRR_BASE) begin
        d.seg = SEG_ADDR_R;
        base  = RD_ADDRR_BASE;
      end else if (step >= RD_RSTRT_BASE) begin
        d.seg = SEG_START;
        base  = RD_RSTRT_BASE;
      end else if (step >= RD_RACK0_BASE) begin
        d.seg = SEG_RACK;
        base  = RD_RACK0_BASE;
      end else if (step >= RD_ADDRW_BASE) begin
        d.seg = SEG_ADDR_W;
        base  = RD_ADDRW_BASE;
      end
      d.last = (step == RD_LAST);
    end else begin
      if (step >= WR_STOP_BASE) begin
        d.seg = SEG_STOP;
        base  = WR_STOP_BASE;
      end else if (step >= WR_RACK1_BASE) begin
        d.seg = SEG_RACK;
        base  = WR_RACK1_BASE;
      end else if (step >= WR_DATA_BASE) begin
        d.seg = SEG_DATA;
        base  = WR_DATA_BASE;
      end else if (step >= WR_RACK0_BASE) begin
        d.seg = SEG_RACK;
        base  = WR_RACK0_BASE;
      end else if (step >= WR_ADDR_BASE) begin
        d.seg = SEG_ADDR_W;
        base  = WR_ADDR_BASE;
      end
      d.last = (step == WR_LAST);
    end
    d.off = OFF_W'(step - base);
    return d;
  endfunction

  // Bit index of a three-step bit slot, valid for offsets up to 23.
  function automatic logic [2:0] slot_index(logic [OFF_W-1:0] v);
    logic [8:0] p;
    p = 9'(v) * 9'd11;
    return p[7:5];
  endfunction

  // Phase within a three-step bit slot.
  function automatic logic [1:0] slot_phase(logic [OFF_W-1:0] v);
    logic [OFF_W-1:0] t;
    t = OFF_W'(slot_index(v)) * OFF_W'(3);
    return 2'(v - t);
  endfunction

endpackage

@@ hdl/i2cm_seq.sv @@
// Transfer sequencer: holds the bus state and computes one pin step per tick word.
// Depends on i2cm_pkg.
module i2cm_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  logic [1:0]        cmd,
  input  logic [7:0]        write_byte,
  input  logic              sda_sample,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_addr,
  output i2cm_pkg::res_t    res
);
  import i2cm_pkg::*;

  logic [6:0]        slave_addr_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              is_read_r, is_read_nxt;
  logic              active_r, active_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [7:0]        received_r, received_nxt;
  logic              nack_r, nack_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              done;

  dec_t              dec;
  logic [2:0]        tx_idx, rx_idx;
  logic [1:0]        tx_ph, rx_ph;
  logic [OFF_W-1:0]  rx_off;
  logic [7:0]        tx_byte;

  assign dec    = step_decode(is_read_r, step_r);
  assign rx_off = dec.off - OFF_W'(1);
  assign tx_idx = slot_index(dec.off);
  assign tx_ph  = slot_phase(dec.off);
  assign rx_idx = slot_index(rx_off);
  assign rx_ph  = slot_phase(rx_off);

  always_comb begin
    case (dec.seg)
      SEG_ADDR_W: tx_byte = {slave_addr_r, 1'b0};
      SEG_ADDR_R: tx_byte = {slave_addr_r, 1'b1};
      default:    tx_byte = shift_r;
    endcase
  end

  always_comb begin
    step_nxt     = step_r;
    is_read_nxt  = is_read_r;
    active_nxt   = active_r;
    shift_nxt    = shift_r;
    received_nxt = received_r;
    nack_nxt     = nack_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    done         = 1'b0;
    if ((cmd == CMD_WRITE || cmd == CMD_READ) && !active_r) begin
      active_nxt  = 1'b1;
      is_read_nxt = (cmd == CMD_READ);
      step_nxt    = '0;
      nack_nxt    = 1'b0;
      shift_nxt   = (cmd == CMD_READ) ? 8'h00 : write_byte;
    end else if (cmd == CMD_TICK && active_r) begin
      case (dec.seg)
        SEG_START: begin
          case (dec.off[1:0])
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            2'd2:    sda_nxt = 1'b0;
            default: scl_nxt = 1'b0;
          endcase
        end
        SEG_ADDR_W, SEG_ADDR_R, SEG_DATA: begin
          case (tx_ph)
            2'd0:    sda_nxt = tx_byte[~tx_idx];
            2'd1:    scl_nxt = 1'b1;
            default: scl_nxt = 1'b0;
          endcase
        end
        SEG_RACK: begin
          case (dec.off[1:0])
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            2'd2:    nack_nxt = nack_r | sda_sample;
            default: scl_nxt = 1'b0;
          endcase
        end
        SEG_RECV: begin
          if (dec.off == '0) begin
            sda_nxt = 1'b1;
          end else begin
            case (rx_ph)
              2'd0: scl_nxt = 1'b1;
              2'd1: begin
                if (sda_sample) begin
                  shift_nxt[~rx_idx] = 1'b1;
                end
              end
              default: scl_nxt = 1'b0;
            endcase
          end
        end
        SEG_SACK: begin
          case (dec.off[1:0])
            2'd0:    sda_nxt = 1'b1;
            2'd1:    scl_nxt = 1'b1;
            default: scl_nxt = 1'b0;
          endcase
        end
        default: begin
          case (dec.off[1:0])
            2'd0:    sda_nxt = 1'b0;
            2'd1:    scl_nxt = 1'b1;
            default: sda_nxt = 1'b1;
          endcase
        end
      endcase
      if (dec.last) begin
        active_nxt = 1'b0;
        done       = 1'b1;
        step_nxt   = '0;
        if (is_read_r) begin
          received_nxt = shift_r;
        end
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  always_comb begin
    res.scl_level = scl_nxt;
    res.sda_level = sda_nxt;
    res.busy_res  = active_nxt;
    res.done_res  = done;
    res.read_byte = received_nxt;
    res.nack_seen = nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= ADDR_RESET;
      step_r       <= '0;
      is_read_r    <= 1'b0;
      active_r     <= 1'b0;
      shift_r      <= '0;
      received_r   <= '0;
      nack_r       <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
    end else begin
      if (cfg_we) begin
        slave_addr_r <= cfg_addr;
      end
      if (step_en) begin
        step_r     <= step_nxt;
        is_read_r  <= is_read_nxt;
        active_r   <= active_nxt;
        shift_r    <= shift_nxt;
        received_r <= received_nxt;
        nack_r     <= nack_nxt;
        scl_r      <= scl_nxt;
        sda_r      <= sda_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= RD_LAST) else $error("step index beyond the read plan");
  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> step_r == '0) else $error("step index not cleared while idle");
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && !is_read_r) |-> step_r <= WR_LAST)
    else $error("step index beyond the write plan");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && done) |=> (!active_r && scl_r && sda_r))
    else $error("bus not released after stop");
`endif

endmodule

@@ hdl/i2cm_out_stage.sv @@
// Result register: holds one finished result word until it is taken.
// Depends on i2cm_pkg.
module i2cm_out_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  i2cm_pkg::res_t  res,
  input  logic            out_ready,
  output logic            out_valid,
  output i2cm_pkg::res_t  out_res
);
  import i2cm_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

@@ hdl/i2c_master_single_byte.sv @@
// Top level of the single-byte I2C master: input register, sequencer and
// result register. Depends on i2cm_pkg, i2cm_seq and i2cm_out_stage.
//
// Each input word is one command: a tick that advances the bus by one pin
// step while active, a write or read request that is taken only while idle,
// or code 3, which does nothing. Every word yields exactly one result word
// with the SCL and SDA levels, busy, done, the last received byte and the
// nack flag. The block takes one word per clock while result words are
// taken; the input register takes the word and the combinational step logic
// loads the result register. A result word that is not taken holds the
// input register, which then holds off the next input word. A write
// transfer takes 63 ticks, a read transfer 95. The address register resets
// to 24 and is written through the cfg port, always ready.
module i2c_master_single_byte (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_write_byte,
  input  logic       in_sda_sample,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_read_byte,
  output logic       out_nack_seen,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_slave_address
);
  import i2cm_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [1:0] cmd_r;
  logic [7:0] write_byte_r;
  logic       sda_sample_r;
  logic       advance;
  logic       res_valid;
  res_t       step_res;
  res_t       out_res;

  assign advance  = in_valid_r && (!res_valid || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r        <= in_cmd;
      write_byte_r <= in_write_byte;
      sda_sample_r <= in_sda_sample;
    end
  end

  i2cm_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .cmd        (cmd_r),
    .write_byte (write_byte_r),
    .sda_sample (sda_sample_r),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_addr   (cfg_slave_address),
    .res        (step_res)
  );

  i2cm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (step_res),
    .out_ready (out_ready),
    .out_valid (res_valid),
    .out_res   (out_res)
  );

  assign out_valid     = res_valid;
  assign out_scl_level = out_res.scl_level;
  assign out_sda_level = out_res.sda_level;
  assign out_busy_res  = out_res.busy_res;
  assign out_done_res  = out_res.done_res;
  assign out_read_byte = out_res.read_byte;
  assign out_nack_seen = out_res.nack_seen;

endmodule

@@ tb/i2c_master_single_byte_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the single-byte I2C master: watches the command, address and
// result channels, predicts every result word and compares it. Uses i2cm_pkg.
module i2c_master_single_byte_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_write_byte,
  input  logic       in_sda_sample,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_scl_level,
  input  logic       out_sda_level,
  input  logic       out_busy_res,
  input  logic       out_done_res,
  input  logic [7:0] out_read_byte,
  input  logic       out_nack_seen,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [6:0] cfg_slave_address,
  output int         fail_count,
  output int         words_pending
);
  import i2cm_pkg::*;

  logic [6:0] addr_r;
  logic [6:0] step_r;
  logic       rd_r;
  logic       busy_r;
  logic [7:0] shift_r;
  logic [7:0] rx_r;
  logic       nack_r;
  logic       scl_r;
  logic       sda_r;
  res_t       bus_levels_q[$];
  int         errs = 0;

  function automatic seg_t plan_seg(input logic rd, input int unsigned idx);
    if (rd) begin
      case (idx)
        0:       return SEG_START;
        1:       return SEG_ADDR_W;
        2:       return SEG_RACK;
        3:       return SEG_START;
        4:       return SEG_ADDR_R;
        5:       return SEG_RACK;
        6:       return SEG_RECV;
        7:       return SEG_SACK;
        default: return SEG_STOP;
      endcase
    end
    case (idx)
      0:       return SEG_START;
      1:       return SEG_ADDR_W;
      2:       return SEG_RACK;
      3:       return SEG_DATA;
      4:       return SEG_RACK;
      default: return SEG_STOP;
    endcase
  endfunction

  function automatic int unsigned seg_steps(input seg_t s);
    case (s)
      SEG_START, SEG_RACK:             return 4;
      SEG_ADDR_W, SEG_ADDR_R, SEG_DATA: return 24;
      SEG_RECV:                        return 25;
      default:                         return 3;
    endcase
  endfunction

  task automatic send_slot(input logic [7:0] b, input int unsigned off);
    case (off % 3)
      0:       sda_r = b[7 - off / 3];
      1:       scl_r = 1'b1;
      default: scl_r = 1'b0;
    endcase
  endtask

  task automatic advance_pins(input logic sda_in, output logic last);
    int unsigned off;
    int unsigned s;
    int unsigned nseg;
    int unsigned o;
    seg_t        seg;
    off  = step_r;
    s    = 0;
    nseg = rd_r ? 9 : 6;
    while (s < nseg && off >= seg_steps(plan_seg(rd_r, s))) begin
      off -= seg_steps(plan_seg(rd_r, s));
      s++;
    end
    if (s >= nseg) begin
      last = 1'b1;
      return;
    end
    seg = plan_seg(rd_r, s);
    case (seg)
      SEG_START: begin
        case (off)
          0:       sda_r = 1'b1;
          1:       scl_r = 1'b1;
          2:       sda_r = 1'b0;
          default: scl_r = 1'b0;
        endcase
      end
      SEG_ADDR_W: send_slot({addr_r, 1'b0}, off);
      SEG_ADDR_R: send_slot({addr_r, 1'b1}, off);
      SEG_DATA:   send_slot(shift_r, off);
      SEG_RACK: begin
        case (off)
          0:       sda_r = 1'b1;
          1:       scl_r = 1'b1;
          2:       nack_r = nack_r | sda_in;
          default: scl_r = 1'b0;
        endcase
      end
      SEG_RECV: begin
        if (off == 0) begin
          sda_r = 1'b1;
        end else begin
          o = off - 1;
          case (o % 3)
            0: scl_r = 1'b1;
            1: if (sda_in) shift_r[7 - o / 3] = 1'b1;
            default: scl_r = 1'b0;
          endcase
        end
      end
      SEG_SACK: begin
        case (off)
          0:       sda_r = 1'b1;
          1:       scl_r = 1'b1;
          default: scl_r = 1'b0;
        endcase
      end
      default: begin
        case (off)
          0:       sda_r = 1'b0;
          1:       scl_r = 1'b1;
          default: sda_r = 1'b1;
        endcase
      end
    endcase
    last = (s == nseg - 1) && (off == seg_steps(seg) - 1);
  endtask

  task automatic predict_levels(input logic [1:0] cmd, input logic [7:0] wb,
                                input logic sda_in);
    res_t r;
    logic last;
    logic done;
    done = 1'b0;
    if (cmd == CMD_WRITE || cmd == CMD_READ) begin
      if (!busy_r) begin
        busy_r  = 1'b1;
        rd_r    = (cmd == CMD_READ);
        step_r  = '0;
        nack_r  = 1'b0;
        shift_r = rd_r ? 8'h00 : wb;
      end
    end else if (cmd == CMD_TICK && busy_r) begin
      advance_pins(sda_in, last);
      if (last) begin
        busy_r = 1'b0;
        done   = 1'b1;
        step_r = '0;
        if (rd_r) rx_r = shift_r;
      end else begin
        step_r = step_r + 7'd1;
      end
    end
    r.scl_level = scl_r;
    r.sda_level = sda_r;
    r.busy_res  = busy_r;
    r.done_res  = done;
    r.read_byte = rx_r;
    r.nack_seen = nack_r;
    bus_levels_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (!rst_n) begin
      addr_r  = ADDR_RESET;
      step_r  = '0;
      rd_r    = 1'b0;
      busy_r  = 1'b0;
      shift_r = '0;
      rx_r    = '0;
      nack_r  = 1'b0;
      scl_r   = 1'b1;
      sda_r   = 1'b1;
      bus_levels_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (bus_levels_q.size() == 0) begin
          $error("result word arrived with no prediction waiting");
          errs++;
        end else begin
          want = bus_levels_q.pop_front();
          check_field("scl_level", 8'(want.scl_level), 8'(out_scl_level));
          check_field("sda_level", 8'(want.sda_level), 8'(out_sda_level));
          check_field("busy_res", 8'(want.busy_res), 8'(out_busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_done_res));
          check_field("read_byte", want.read_byte, out_read_byte);
          check_field("nack_seen", 8'(want.nack_seen), 8'(out_nack_seen));
        end
      end
      if (cfg_valid && cfg_ready) addr_r = cfg_slave_address;
      if (in_valid && in_ready) predict_levels(in_cmd, in_write_byte, in_sda_sample);
    end
    fail_count    <= errs;
    words_pending <= bus_levels_q.size();
  end

endmodule

@@ tb/i2c_master_single_byte_tb.sv @@
`timescale 1ns / 1ps
// Top of the single-byte I2C master testbench: clock, reset, command and
// address stimulus, result backpressure and the verdict. Uses i2cm_pkg,
// i2c_master_single_byte and i2c_master_single_byte_checker.
module i2c_master_single_byte_tb;
  import i2cm_pkg::*;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int unsigned STALL_LIMIT = 400;
  localparam int unsigned WORD_TARGET = 1975;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_cmd = CMD_TICK;
  logic [7:0] in_write_byte = 8'h00;
  logic       in_sda_sample = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_scl_level;
  logic       out_sda_level;
  logic       out_busy_res;
  logic       out_done_res;
  logic [7:0] out_read_byte;
  logic       out_nack_seen;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_slave_address = 7'd0;
  int         fail_count;
  int         words_pending;
  logic       calm = 1'b0;
  int         n_words = 0;
  int         n_wr = 0;
  int         n_rd = 0;
  int         n_cfg = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  i2c_master_single_byte u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_write_byte     (in_write_byte),
    .in_sda_sample     (in_sda_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scl_level     (out_scl_level),
    .out_sda_level     (out_sda_level),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_read_byte     (out_read_byte),
    .out_nack_seen     (out_nack_seen),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_slave_address (cfg_slave_address)
  );

  i2c_master_single_byte_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_write_byte     (in_write_byte),
    .in_sda_sample     (in_sda_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scl_level     (out_scl_level),
    .out_sda_level     (out_sda_level),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_read_byte     (out_read_byte),
    .out_nack_seen     (out_nack_seen),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_slave_address (cfg_slave_address),
    .fail_count        (fail_count),
    .words_pending     (words_pending)
  );

  task automatic push_word(input logic [1:0] cmd, input logic [7:0] wb, input logic sda);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(6, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_write_byte <= wb;
    in_sda_sample <= sda;
    do @(posedge clk); while (!in_ready);
    n_words++;
    if (cmd == CMD_WRITE) n_wr++;
    if (cmd == CMD_READ) n_rd++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  task automatic set_address(input logic [6:0] a);
    cfg_slave_address <= a;
    cfg_valid         <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  // Line mode 0 always acknowledges, 1 always reads high, 2 is random.
  task automatic run_transfer(input logic rd, input logic [7:0] wb,
                              input int unsigned line_mode, input bit broken);
    int unsigned len;
    int unsigned k;
    logic        sda;
    len = rd ? 95 : 63;
    if (broken) len = $urandom_range(len - 1, 1);
    push_word(rd ? CMD_READ : CMD_WRITE, wb, 1'($urandom));
    for (k = 0; k < len; k++) begin
      if ($urandom_range(19, 0) == 0)
        push_word(2'($urandom_range(3, 1)), 8'($urandom), 1'($urandom));
      sda = (line_mode == 0) ? 1'b0 : (line_mode == 1) ? 1'b1 : 1'($urandom);
      push_word(CMD_TICK, 8'($urandom), sda);
    end
  endtask

  initial begin : stimulus
    int unsigned k;
    int unsigned xfer;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_word(CMD_TICK, 8'h00, 1'b0);
    push_word(CMD_TICK, 8'hFF, 1'b1);
    push_word(CMD_NOP, 8'hA5, 1'b1);
    push_word(CMD_WRITE, 8'hFF, 1'b0);
    push_word(CMD_WRITE, 8'h00, 1'b1);
    push_word(CMD_READ, 8'h5A, 1'b0);
    push_word(CMD_NOP, 8'h3C, 1'b0);
    for (k = 0; k < 16; k++) push_word(CMD_TICK, 8'($urandom), k[0]);

    xfer = 0;
    while (n_words < WORD_TARGET) begin
      if (xfer % 5 == 4) begin
        calm = 1'b0;
        drain();
        case ((xfer / 5) % 3)
          0:       set_address(7'h00);
          1:       set_address(7'h7F);
          default: set_address(7'($urandom));
        endcase
      end
      calm = ($urandom_range(3, 0) == 0);
      if ($urandom_range(3, 0) == 0)
        push_word($urandom_range(1, 0) ? CMD_TICK : CMD_NOP, 8'($urandom), 1'($urandom));
      run_transfer(1'($urandom), 8'($urandom), $urandom_range(2, 0),
                   $urandom_range(7, 0) == 0);
      xfer++;
    end

    calm = 1'b0;
    drain();
    repeat (8) @(posedge clk);
    $display("Run covered %0d command words, %0d write and %0d read requests, %0d address writes.",
             n_words, n_wr, n_rd, n_cfg);
    if (fail_count == 0) begin
      $display("PASS i2c_master_single_byte");
    end else begin
      $display("FAIL i2c_master_single_byte");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(6, 0);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL i2c_master_single_byte");
    $finish;
  end

endmodule

@@ i2c_master_single_byte.f @@
hdl/i2cm_pkg.sv
hdl/i2cm_seq.sv
hdl/i2cm_out_stage.sv
hdl/i2c_master_single_byte.sv
tb/i2c_master_single_byte_checker.sv
tb/i2c_master_single_byte_tb.sv
